// ===== hdl/rtp_pcmu_packetizer_top_assert.svh =====
// ----------------------------------------------------------------------------
// RTP PCMU packetizer assertion macros
// Concurrent assertion wrappers shared by the packetizer RTL.
// ----------------------------------------------------------------------------
`ifndef RTP_PCMU_PACKETIZER_TOP_ASSERT_SVH
`define RTP_PCMU_PACKETIZER_TOP_ASSERT_SVH

// same-cycle implication
`define RTP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rtp packetizer assertion failed");

// next-cycle implication
`define RTP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rtp packetizer assertion failed");

`endif

// ===== hdl/rtp_pkg.sv =====
// ----------------------------------------------------------------------------
// RTP PCMU packetizer package
// Transaction types, header and mu-law constants, configuration indexes.
// ----------------------------------------------------------------------------
package rtp_pkg;

    localparam int SAMPLES_PER_PACKET = 160;
    localparam int HDR_BYTES          = 12;
    localparam int HDR_CNT_W          = $clog2(HDR_BYTES + 1);
    localparam int SIDX_W             = 8;

    localparam logic [SIDX_W-1:0] SIDX_LAST = SIDX_W'(SAMPLES_PER_PACKET - 1);
    localparam logic [31:0]       TS_STEP   = 32'(SAMPLES_PER_PACKET);

    localparam logic [7:0]  RTP_V2_BYTE  = 8'h80;
    localparam logic [14:0] ULAW_CLIP    = 15'd32635;
    localparam logic [14:0] ULAW_BIAS    = 15'h84;
    localparam logic [7:0]  ULAW_SILENCE = 8'hFF;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SSRC     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_SEQ = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_TS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PT       = 2'd3;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_START  = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic signed [15:0] pcm_sample;
        logic               silent;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } t_out_item;

endpackage

// ===== hdl/rtp_ulaw_enc.sv =====
// ----------------------------------------------------------------------------
// RTP mu-law encoder
// G.711 mu-law byte from a 16-bit linear sample, or the silence byte.
// ----------------------------------------------------------------------------
module rtp_ulaw_enc
    import rtp_pkg::*;
(
    input  logic signed [15:0] i_sample,
    input  logic               i_silent,
    output logic [7:0]         o_byte
);

    logic        w_sign;
    logic [15:0] w_mag;
    logic [14:0] w_clamped;
    logic [14:0] w_biased;
    logic [2:0]  w_expo;
    logic [3:0]  w_mant;
    logic [3:0]  w_shift;

    assign w_sign    = i_sample[15];
    assign w_mag     = w_sign ? 16'(-i_sample) : i_sample;
    assign w_clamped = (w_mag > 16'(ULAW_CLIP)) ? ULAW_CLIP : w_mag[14:0];
    assign w_biased  = w_clamped + ULAW_BIAS;

    always_comb begin
        w_expo = '0;
        for (int k = 0; k < 8; k++) begin
            if (w_biased[k+7]) begin
                w_expo = 3'(k);
            end
        end
    end

    assign w_shift = {1'b0, w_expo} + 4'd3;
    assign w_mant  = 4'(w_biased >> w_shift);
    assign o_byte  = i_silent ? ULAW_SILENCE : ~{w_sign, w_expo, w_mant};

endmodule

// ===== hdl/rtp_pcmu_packetizer_top.sv =====
// ----------------------------------------------------------------------------
// RTP PCMU packetizer
// Each sample transaction yields one mu-law payload byte; the first sample of
// a packet is preceded by the 12-byte RTP header, so a 160-sample packet is
// 172 bytes. The header bytes come one per cycle while the output is not
// stalled, from a byte counter over the registered sample; the output
// register is the limit. A start transaction produces no bytes. The input
// side is taken while the previous result still waits in the output register.
// ----------------------------------------------------------------------------
`include "rtp_pcmu_packetizer_top_assert.svh"

module rtp_pcmu_packetizer_top
    import rtp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [31:0]          r_ssrc;
    logic [15:0]          r_init_seq;
    logic [31:0]          r_init_ts;
    logic [6:0]           r_pt;

    logic [15:0]          r_seq;
    logic [31:0]          r_ts;
    logic [SIDX_W-1:0]    r_sample_idx;
    logic                 r_marker;

    logic                 r_busy;
    t_in_item             r_item;
    logic [HDR_CNT_W-1:0] r_hdr_cnt;

    logic                 r_out_valid;
    t_out_item            r_out;
    t_out_item            n_out;

    logic                 w_out_free;
    logic                 w_is_cmd;
    logic                 w_hdr_phase;
    logic                 w_step;
    logic                 w_finish;
    logic                 w_emit;
    logic                 w_in_acc;
    logic                 w_pkt_end;
    logic [95:0]          w_hdr;
    logic [6:0]           w_hdr_bit;
    logic [7:0]           w_payload;

    rtp_ulaw_enc u_enc (
        .i_sample (r_item.pcm_sample),
        .i_silent (r_item.silent),
        .o_byte   (w_payload)
    );

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_is_cmd    = (r_item.cmd == CMD_START);
    assign w_hdr_phase = (r_sample_idx == '0) && (r_hdr_cnt != HDR_CNT_W'(HDR_BYTES));
    assign w_step      = r_busy && (w_is_cmd || w_out_free);
    assign w_finish    = w_step && (w_is_cmd || !w_hdr_phase);
    assign w_emit      = w_step && !w_is_cmd;
    assign w_pkt_end   = (r_sample_idx == SIDX_LAST);

    assign o_in_stall  = r_busy && !w_finish;
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign w_hdr     = {RTP_V2_BYTE, r_marker, r_pt, r_seq, r_ts, r_ssrc};
    assign w_hdr_bit = 7'd95 - {r_hdr_cnt, 3'b000};

    always_comb begin
        if (w_hdr_phase) begin
            n_out.out_byte = w_hdr[w_hdr_bit -: 8];
            n_out.last     = 1'b0;
        end else begin
            n_out.out_byte = w_payload;
            n_out.last     = w_pkt_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ssrc       <= '0;
            r_init_seq   <= '0;
            r_init_ts    <= '0;
            r_pt         <= '0;
            r_seq        <= '0;
            r_ts         <= '0;
            r_sample_idx <= '0;
            r_marker     <= 1'b1;
            r_busy       <= 1'b0;
            r_hdr_cnt    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_SSRC:     r_ssrc     <= i_cfg_data;
                    CFG_INIT_SEQ: r_init_seq <= i_cfg_data[15:0];
                    CFG_INIT_TS:  r_init_ts  <= i_cfg_data;
                    CFG_PT:       r_pt       <= i_cfg_data[6:0];
                    default:      ;
                endcase
            end

            r_busy <= w_in_acc || (r_busy && !w_finish);
            if (w_in_acc) begin
                r_item <= i_in_item;
            end

            r_out_valid <= w_emit || (r_out_valid && i_out_stall);
            if (w_emit) begin
                r_out <= n_out;
            end

            if (w_step) begin
                if (w_is_cmd) begin
                    r_seq        <= r_init_seq;
                    r_ts         <= r_init_ts;
                    r_sample_idx <= '0;
                    r_marker     <= 1'b1;
                    r_hdr_cnt    <= '0;
                end else if (w_hdr_phase) begin
                    r_hdr_cnt <= r_hdr_cnt + 1'b1;
                end else begin
                    r_hdr_cnt <= '0;
                    if (r_sample_idx == '0) begin
                        r_marker <= 1'b0;
                    end
                    if (w_pkt_end) begin
                        r_sample_idx <= '0;
                        r_seq        <= r_seq + 16'd1;
                        r_ts         <= r_ts + TS_STEP;
                    end else begin
                        r_sample_idx <= r_sample_idx + 1'b1;
                    end
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `RTP_ASSERT_NOW(a_hdr_cnt_range, i_clk, i_rst_n, 1'b1, r_hdr_cnt <= HDR_CNT_W'(HDR_BYTES))
    `RTP_ASSERT_NOW(a_stall_only_busy, i_clk, i_rst_n, o_in_stall, r_busy && !w_is_cmd)
    `RTP_ASSERT_NOW(a_hdr_only_at_start, i_clk, i_rst_n, w_emit && w_hdr_phase, r_sample_idx == '0)
    `RTP_ASSERT_NEXT(a_last_closes_pkt, i_clk, i_rst_n, w_emit && n_out.last, r_sample_idx == '0)

endmodule

// ===== test/rtp_pcmu_packetizer_top_test.sv =====
// ----------------------------------------------------------------------------
// RTP PCMU packetizer testbench
// Feeds sample and start transactions under random gaps and output stalls,
// with one long output hold-off. A scoreboard predicts every header and
// mu-law payload byte and compares each output transaction with it.
// ----------------------------------------------------------------------------
module rtp_pcmu_packetizer_top_test;
    import rtp_pkg::*;

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  in_valid  = 1'b0;
    t_in_item              in_item   = '0;
    logic                  out_stall = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out_item             o_out_item;
    logic                  o_cfg_ready;

    t_in_item  pend_items[$];
    t_out_item due_bytes[$];

    logic [31:0] cfg_ssrc = '0;
    logic [15:0] cfg_seq0 = '0;
    logic [31:0] cfg_ts0  = '0;
    logic [6:0]  cfg_pt   = '0;

    logic [15:0] seq_ctr    = '0;
    logic [31:0] ts_ctr     = '0;
    logic [7:0]  pkt_fill   = '0;
    logic        mark_armed = 1'b1;

    int   in_wait      = 0;
    int   out_wait     = 0;
    logic calm         = 1'b0;
    logic rx_hold      = 1'b0;
    int   taken_items  = 0;
    int   starts_taken = 0;
    int   bytes_seen   = 0;
    int   pkts_closed  = 0;
    int   mismatches   = 0;

    rtp_pcmu_packetizer_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic int idle_draw();
        if (calm || $urandom_range(0, 1) == 0) begin
            return 0;
        end
        return $urandom_range(1, 7);
    endfunction

    function automatic logic [7:0] ulaw_byte(input logic signed [15:0] s);
        int         mag;
        int         ex;
        logic [3:0] mant;
        mag = (s < 0) ? -int'(s) : int'(s);
        if (mag > int'(ULAW_CLIP)) begin
            mag = int'(ULAW_CLIP);
        end
        mag = mag + int'(ULAW_BIAS);
        ex = 7;
        while (ex > 0 && mag[ex + 7] == 1'b0) begin
            ex--;
        end
        mant = 4'(mag >> (ex + 3));
        return ~{s[15], 3'(ex), mant};
    endfunction

    task automatic packetize(input t_in_item it);
        logic [7:0] pay;
        if (it.cmd == CMD_START) begin
            seq_ctr    = cfg_seq0;
            ts_ctr     = cfg_ts0;
            pkt_fill   = '0;
            mark_armed = 1'b1;
            starts_taken++;
        end else begin
            if (pkt_fill == 0) begin
                due_bytes.push_back('{RTP_V2_BYTE, 1'b0});
                due_bytes.push_back('{{mark_armed, cfg_pt}, 1'b0});
                due_bytes.push_back('{seq_ctr[15:8], 1'b0});
                due_bytes.push_back('{seq_ctr[7:0], 1'b0});
                for (int k = 3; k >= 0; k--) begin
                    due_bytes.push_back('{ts_ctr[8*k +: 8], 1'b0});
                end
                for (int k = 3; k >= 0; k--) begin
                    due_bytes.push_back('{cfg_ssrc[8*k +: 8], 1'b0});
                end
                mark_armed = 1'b0;
            end
            pay = it.silent ? ULAW_SILENCE : ulaw_byte(it.pcm_sample);
            pkt_fill = pkt_fill + 8'd1;
            if (pkt_fill >= SAMPLES_PER_PACKET) begin
                due_bytes.push_back('{pay, 1'b1});
                pkt_fill = '0;
                seq_ctr  = seq_ctr + 16'd1;
                ts_ctr   = ts_ctr + TS_STEP;
            end else begin
                due_bytes.push_back('{pay, 1'b0});
            end
        end
    endtask

    task automatic check_byte(input t_out_item got);
        t_out_item want;
        bytes_seen++;
        if (got.last) begin
            pkts_closed++;
        end
        if (due_bytes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("unexpected byte %02h last %0b", got.out_byte, got.last);
            end
        end else begin
            want = due_bytes.pop_front();
            if (got.out_byte !== want.out_byte || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("byte %0d: expected %02h last %0b, got %02h last %0b",
                             bytes_seen, want.out_byte, want.last, got.out_byte, got.last);
                end
            end
        end
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                packetize(in_item);
                taken_items++;
            end
            if (!in_valid || !o_in_stall) begin
                if (in_wait != 0) begin
                    in_wait  = in_wait - 1;
                    in_valid <= 1'b0;
                end else if (pend_items.size() != 0) begin
                    in_item  <= pend_items.pop_front();
                    in_valid <= 1'b1;
                    in_wait  = idle_draw();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                check_byte(o_out_item);
                out_wait = idle_draw();
            end
            if (rx_hold) begin
                out_stall <= 1'b1;
            end else if (out_wait != 0) begin
                out_stall <= 1'b1;
                if (o_out_valid) begin
                    out_wait = out_wait - 1;
                end
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // long output hold-off while the sender keeps offering
    initial begin
        wait (taken_items >= 60);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (250) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d bytes outstanding", due_bytes.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!(cfg_valid && o_cfg_ready));
        case (idx)
            CFG_SSRC:     cfg_ssrc = val;
            CFG_INIT_SEQ: cfg_seq0 = val[15:0];
            CFG_INIT_TS:  cfg_ts0  = val;
            CFG_PT:       cfg_pt   = val[6:0];
            default:      ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        while (pend_items.size() != 0 || in_valid || due_bytes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
    endtask

    function automatic t_in_item audio(input logic signed [15:0] s, input logic q);
        return '{CMD_SAMPLE, s, q};
    endfunction

    function automatic t_in_item audio_item();
        t_in_item it;
        it.cmd = CMD_SAMPLE;
        case ($urandom_range(0, 9))
            0:       it.pcm_sample = 16'sh7FFF;
            1:       it.pcm_sample = 16'sh8000;
            2:       it.pcm_sample = 16'($urandom_range(0, 600)) - 16'sd300;
            default: it.pcm_sample = 16'($urandom);
        endcase
        it.silent = ($urandom_range(0, 7) == 0);
        return it;
    endfunction

    function automatic t_in_item start_item();
        return '{CMD_START, 16'($urandom), 1'($urandom)};
    endfunction

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_reg(CFG_SSRC, 32'hFFFF_FFFF);
        set_reg(CFG_INIT_SEQ, 32'h0000_FFFF);
        set_reg(CFG_INIT_TS, 32'hFFFF_FF60);
        set_reg(CFG_PT, 32'd127);

        // first packet uses counters from reset
        pend_items.push_back(audio(16'sd0, 1'b0));
        pend_items.push_back(audio(16'sd32767, 1'b0));
        pend_items.push_back(audio(-16'sd32768, 1'b0));
        pend_items.push_back(audio(-16'sd1, 1'b0));
        pend_items.push_back(audio(16'sd1, 1'b0));
        pend_items.push_back(audio(16'sd32635, 1'b0));
        pend_items.push_back(audio(16'sd32636, 1'b0));
        pend_items.push_back(audio(-16'sd32635, 1'b0));
        pend_items.push_back(audio(-16'sd32636, 1'b0));
        pend_items.push_back(audio(16'sd5, 1'b0));
        pend_items.push_back(audio(16'sh1234, 1'b1));
        pend_items.push_back(audio(-16'sd32768, 1'b1));
        pend_items.push_back(start_item());
        pend_items.push_back(audio(16'sd100, 1'b0));
        pend_items.push_back(audio(-16'sd100, 1'b0));
        pend_items.push_back(audio(16'sd16384, 1'b0));
        pend_items.push_back(audio(-16'sd16384, 1'b0));
        pend_items.push_back(start_item());
        pend_items.push_back(start_item());
        pend_items.push_back(audio(16'sd32767, 1'b0));
        settle();

        // full packet across sequence and timestamp wrap, back-to-back
        calm = 1'b1;
        set_reg(CFG_SSRC, $urandom);
        set_reg(CFG_PT, 32'd0);
        pend_items.push_back(start_item());
        repeat (165) pend_items.push_back(audio_item());
        settle();

        calm = 1'b0;
        set_reg(CFG_SSRC, 32'd0);
        set_reg(CFG_INIT_SEQ, $urandom_range(0, 65535));
        set_reg(CFG_INIT_TS, $urandom);
        set_reg(CFG_PT, $urandom_range(0, 127));
        pend_items.push_back(start_item());
        repeat (135) begin
            pend_items.push_back(($urandom_range(0, 19) == 0) ? start_item() : audio_item());
        end
        settle();

        if (due_bytes.size() != 0) begin
            mismatches = mismatches + due_bytes.size();
            $display("%0d expected bytes never arrived", due_bytes.size());
        end
        $display("covered %0d input transactions (%0d starts), %0d bytes out, %0d packets closed",
                 taken_items, starts_taken, bytes_seen, pkts_closed);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/rtp_pkg.sv
hdl/rtp_ulaw_enc.sv
hdl/rtp_pcmu_packetizer_top.sv
test/rtp_pcmu_packetizer_top_test.sv
